// ===== design/letter_count_rle_codec_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the letter count run-length codec
// Concurrent check wrappers with a shared clock, reset and message form.
// ---------------------------------------------------------------------------
`ifndef LETTER_COUNT_RLE_CODEC_MACROS_SVH
`define LETTER_COUNT_RLE_CODEC_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCRLE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCRLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lcrle_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcrle_pkg
// Shared types and constants of the letter count run-length codec.
// ---------------------------------------------------------------------------
package lcrle_pkg;

    // Longest run packed into one triplet
    localparam int MAX_RUN = 26;
    // Run and repeat counters cover 1..26
    localparam int RUN_W = 5;

    localparam logic [7:0] MARK_BYTE = 8'h51;  // 'Q'
    localparam logic [7:0] LETTER_A  = 8'h41;  // 'A'
    localparam logic [7:0] LETTER_Z  = 8'h5A;  // 'Z'

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } lcrle_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       bad_input;
    } lcrle_out_t;

    // Controller to datapath
    typedef struct packed {
        logic load_job;  // input transfer: update state, latch result job
        logic emit;      // load next result into output register
    } lcrle_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic job_nonempty;  // item at the input produces results
        logic emit_final;    // current result is the last of the job
    } lcrle_status_t;

endpackage

// ===== design/lcrle_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcrle_ctrl
// Sequencer: takes input transfers and paces result transfers.
// ---------------------------------------------------------------------------
module lcrle_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output lcrle_pkg::lcrle_cmd_t   cmd,
    input  lcrle_pkg::lcrle_status_t status
);
    import lcrle_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic can_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign can_load = !out_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd.load_job = 1'b0;
        cmd.emit     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_job = 1'b1;
                    if (status.job_nonempty) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            default: begin
                if (can_load) begin
                    cmd.emit = 1'b1;
                    if (status.emit_final) begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/lcrle_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcrle_datapath
// Codec state, result job registers and the output payload register.
// ---------------------------------------------------------------------------
module lcrle_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic                     cfg_data,
    input  lcrle_pkg::lcrle_in_t     s_data,
    input  lcrle_pkg::lcrle_cmd_t    cmd,
    output lcrle_pkg::lcrle_status_t status,
    output lcrle_pkg::lcrle_out_t    m_data
);
    import lcrle_pkg::*;

    localparam logic [1:0] PH_MARK   = 2'd0;
    localparam logic [1:0] PH_LETTER = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;

    localparam logic [1:0] POS_MARK  = 2'd0;
    localparam logic [1:0] POS_COUNT = 2'd1;
    localparam logic [1:0] POS_DATA  = 2'd2;

    // Codec state
    logic             dir_reg;
    logic             run_open_reg;
    logic [7:0]       run_byte_reg;
    logic [RUN_W-1:0] run_count_reg;
    logic [1:0]       phase_reg;
    logic [7:0]       letter_reg;

    // Result job
    logic             job_dec_reg;
    logic [7:0]       a_byte_reg, b_byte_reg;
    logic [RUN_W-1:0] a_cnt_reg, b_cnt_reg;
    logic             b_en_reg;
    logic             sel_reg;
    logic [1:0]       pos_reg;
    logic [7:0]       rep_byte_reg;
    logic [RUN_W-1:0] rep_left_reg;
    logic             rep_last_reg;
    logic             rep_bad_reg;
    lcrle_out_t       out_reg;

    // Encode evaluation
    logic             enc_extend, enc_a_en, enc_nonempty;
    logic [7:0]       enc_nb;
    logic [RUN_W-1:0] enc_nc;

    // Decode evaluation
    logic             letter_ok, dec_nonempty, dec_bad;
    logic [7:0]       letter_diff;
    logic [RUN_W-1:0] dec_left;
    logic [1:0]       phase_next;
    logic [7:0]       letter_next;

    // Current result
    lcrle_out_t       cur;
    logic             cur_final;
    logic [7:0]       tri_byte;
    logic [RUN_W-1:0] tri_cnt;

    assign enc_extend   = run_open_reg && (s_data.in_byte == run_byte_reg)
                          && (run_count_reg < RUN_W'(MAX_RUN));
    assign enc_a_en     = run_open_reg && !enc_extend;
    assign enc_nb       = enc_extend ? run_byte_reg : s_data.in_byte;
    assign enc_nc       = enc_extend ? run_count_reg + RUN_W'(1) : RUN_W'(1);
    assign enc_nonempty = enc_a_en || s_data.in_last;

    assign letter_ok    = (letter_reg >= LETTER_A) && (letter_reg <= LETTER_Z);
    assign letter_diff  = letter_reg - LETTER_A;
    assign dec_left     = letter_diff[RUN_W-1:0] + RUN_W'(1);
    assign dec_nonempty = (phase_reg == PH_DATA) || s_data.in_last;
    assign dec_bad      = (phase_reg != PH_DATA) || !letter_ok;

    always_comb begin
        phase_next  = PH_MARK;
        letter_next = 8'd0;
        if (phase_reg == PH_MARK && !s_data.in_last) begin
            phase_next = PH_LETTER;
        end else if (phase_reg == PH_LETTER && !s_data.in_last) begin
            phase_next  = PH_DATA;
            letter_next = s_data.in_byte;
        end
    end

    assign status.job_nonempty = dir_reg ? dec_nonempty : enc_nonempty;
    assign status.emit_final   = cur_final;

    assign tri_byte = sel_reg ? b_byte_reg : a_byte_reg;
    assign tri_cnt  = sel_reg ? b_cnt_reg : a_cnt_reg;

    always_comb begin
        if (job_dec_reg) begin
            cur_final     = rep_bad_reg || (rep_left_reg == RUN_W'(1));
            cur.out_byte  = rep_bad_reg ? 8'd0 : rep_byte_reg;
            cur.out_last  = rep_last_reg && cur_final;
            cur.bad_input = rep_bad_reg;
        end else begin
            cur_final     = (pos_reg == POS_DATA) && (sel_reg || !b_en_reg);
            cur.out_last  = sel_reg && (pos_reg == POS_DATA);
            cur.bad_input = 1'b0;
            unique case (pos_reg)
                POS_MARK:  cur.out_byte = MARK_BYTE;
                POS_COUNT: cur.out_byte = LETTER_A + 8'(tri_cnt) - 8'd1;
                default:   cur.out_byte = tri_byte;
            endcase
        end
    end

    assign m_data = out_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg       <= 1'b0;
            run_open_reg  <= 1'b0;
            run_byte_reg  <= 8'd0;
            run_count_reg <= '0;
            phase_reg     <= PH_MARK;
            letter_reg    <= 8'd0;
            sel_reg       <= 1'b0;
            pos_reg       <= POS_MARK;
        end else begin
            if (cfg_valid) begin
                dir_reg <= cfg_data;
            end
            if (cmd.load_job) begin
                if (dir_reg) begin
                    phase_reg  <= phase_next;
                    letter_reg <= letter_next;
                end else if (s_data.in_last) begin
                    // stream ends: close the run
                    run_open_reg  <= 1'b0;
                    run_byte_reg  <= 8'd0;
                    run_count_reg <= '0;
                end else begin
                    run_open_reg  <= 1'b1;
                    run_byte_reg  <= enc_nb;
                    run_count_reg <= enc_nc;
                end
                sel_reg <= !enc_a_en;
                pos_reg <= POS_MARK;
            end else if (cmd.emit && !job_dec_reg) begin
                if (pos_reg == POS_DATA) begin
                    pos_reg <= POS_MARK;
                    sel_reg <= 1'b1;
                end else begin
                    pos_reg <= pos_reg + 2'd1;
                end
            end
        end
    end

    // Job and payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_job) begin
            job_dec_reg  <= dir_reg;
            a_byte_reg   <= run_byte_reg;
            a_cnt_reg    <= run_count_reg;
            b_byte_reg   <= enc_nb;
            b_cnt_reg    <= enc_nc;
            b_en_reg     <= s_data.in_last;
            rep_byte_reg <= s_data.in_byte;
            rep_left_reg <= dec_left;
            rep_last_reg <= s_data.in_last;
            rep_bad_reg  <= dec_bad;
        end else if (cmd.emit && job_dec_reg) begin
            rep_left_reg <= rep_left_reg - RUN_W'(1);
        end
        if (cmd.emit) begin
            out_reg <= cur;
        end
    end

endmodule

// ===== design/letter_count_rle_codec.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// letter_count_rle_codec
// Byte-stream run-length encoder and decoder with letter count triplets.
// ---------------------------------------------------------------------------
// The cfg channel selects the direction (0 encode, 1 decode); write it only
// while the block is idle. Bytes that produce no result (they extend an
// encode run or start a decode triplet) stream in at one per clock. After a
// byte that produces N results, input waits while the result sequencer loads
// one result per cycle into the output register, while it is free or being
// taken; N is 3 or 6 for encoding and 1 to 26 for decoding. A result waiting
// in the output register does not block the next input transfer.
module letter_count_rle_codec (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lcrle_pkg::lcrle_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lcrle_pkg::lcrle_out_t m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);
    import lcrle_pkg::*;

    lcrle_cmd_t    cmd;
    lcrle_status_t status;

    assign cfg_ready = 1'b1;

    lcrle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    lcrle_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

endmodule

// ===== design/lcrle_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcrle_checker
// Port-level checks of the codec, bound to the top level.
// ---------------------------------------------------------------------------
`include "letter_count_rle_codec_macros.svh"

module lcrle_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input lcrle_pkg::lcrle_in_t  s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input lcrle_pkg::lcrle_out_t m_data,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic                  cfg_data
);

    logic dir_reg;

    // Track the direction from completed cfg transfers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            dir_reg <= cfg_data;
        end
    end

    `LCRLE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "stalled result changed or dropped")

    `LCRLE_ASSERT_SAME(a_bad_zero, aclk, aresetn, m_valid && m_data.bad_input,
        m_data.out_byte == 8'd0, "flagged result carries a nonzero byte")

    `LCRLE_ASSERT_SAME(a_enc_clean, aclk, aresetn, m_valid && !dir_reg,
        !m_data.bad_input, "bad_input set while encoding")

endmodule

bind letter_count_rle_codec lcrle_checker u_checker (.*);

// ===== tb/sv/tb_letter_count_rle_codec.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_letter_count_rle_codec
// Self-checking bench for the letter count run-length codec. Byte streams go
// in over the s_ channel in both directions. A scoreboard predicts every
// encoded triplet or decoded repeat, including error flags, and matches it
// against the m_ channel field by field. Sender gaps and receiver stalls vary
// from phase to phase.
// ---------------------------------------------------------------------------
module tb_letter_count_rle_codec;
    import lcrle_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SEG_ITEMS   = 36;
    localparam int DRAIN_CYC   = 8;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [1:0] PH_MARK  = 2'd0;
    localparam logic [1:0] PH_COUNT = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;

    localparam lcrle_out_t NO_PIN = '0;

    typedef enum logic {ROW_BYTE, ROW_DIR} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [7:0] value;
        logic       last;
        int         reps;
        logic       pinned;
        lcrle_out_t pin;
    } stim_row_t;

    localparam int NROWS = 35;

    // Pinned rows give the newest result that the byte must cause.
    stim_row_t stim_tab [0:NROWS-1] = '{
        '{ROW_BYTE, 8'hFF,          1'b1, 1,  1'b1, '{8'hFF, 1'b1, 1'b0}},
        '{ROW_BYTE, 8'h00,          1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, 8'h00,          1'b1, 1,  1'b1, '{8'h00, 1'b1, 1'b0}},
        '{ROW_BYTE, 8'h12,          1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, 8'h34,          1'b1, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, 8'hA5,          1'b0, 26, 1'b0, NO_PIN},
        '{ROW_BYTE, 8'hA5,          1'b1, 1,  1'b1, '{8'hA5, 1'b1, 1'b0}},
        '{ROW_DIR,  8'(DIR_DECODE), 1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, MARK_BYTE,      1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, LETTER_Z,       1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, 8'h7E,          1'b1, 1,  1'b1, '{8'h7E, 1'b1, 1'b0}},
        '{ROW_BYTE, 8'h00,          1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, LETTER_A,       1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, 8'h00,          1'b0, 1,  1'b1, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE, 8'hFF,          1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, LETTER_A - 8'd1, 1'b0, 1, 1'b0, NO_PIN},
        '{ROW_BYTE, 8'h33,          1'b0, 1,  1'b1, '{8'h00, 1'b0, 1'b1}},
        '{ROW_BYTE, MARK_BYTE,      1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, LETTER_Z + 8'd1, 1'b0, 1, 1'b0, NO_PIN},
        '{ROW_BYTE, 8'h11,          1'b1, 1,  1'b1, '{8'h00, 1'b1, 1'b1}},
        '{ROW_BYTE, MARK_BYTE,      1'b1, 1,  1'b1, '{8'h00, 1'b1, 1'b1}},
        '{ROW_BYTE, MARK_BYTE,      1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, LETTER_A + 8'd1, 1'b1, 1, 1'b1, '{8'h00, 1'b1, 1'b1}},
        '{ROW_DIR,  8'(DIR_ENCODE), 1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, 8'h42,          1'b0, 1,  1'b0, NO_PIN},
        '{ROW_DIR,  8'(DIR_DECODE), 1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, MARK_BYTE,      1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, LETTER_A,       1'b0, 1,  1'b0, NO_PIN},
        '{ROW_DIR,  8'(DIR_ENCODE), 1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, 8'h42,          1'b1, 1,  1'b1, '{8'h42, 1'b1, 1'b0}},
        '{ROW_DIR,  8'(DIR_DECODE), 1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, 8'h99,          1'b1, 1,  1'b1, '{8'h99, 1'b1, 1'b0}},
        '{ROW_BYTE, MARK_BYTE,      1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, 8'hFF,          1'b0, 1,  1'b0, NO_PIN},
        '{ROW_BYTE, 8'h80,          1'b1, 1,  1'b1, '{8'h00, 1'b1, 1'b1}}
    };

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    lcrle_in_t  s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    lcrle_out_t m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    // Predicted codec state
    logic       mode_dir   = DIR_ENCODE;
    logic [7:0] enc_byte   = '0;
    logic [4:0] enc_len    = '0;
    logic       enc_open   = 1'b0;
    logic [1:0] dec_phase  = PH_MARK;
    logic [7:0] dec_letter = '0;

    lcrle_out_t bytes_due [$];
    logic       pin_armed = 1'b0;
    lcrle_out_t pin_want  = '0;
    int         err_cnt   = 0;
    int         cycle_cnt = 0;
    int         src_idle  = 0;
    int         sink_stall = 0;

    letter_count_rle_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall);
    end

    function automatic void push_result(input logic [7:0] b, input logic l, input logic bad);
        lcrle_out_t r;
        r.out_byte  = b;
        r.out_last  = l;
        r.bad_input = bad;
        bytes_due = {bytes_due, r};
    endfunction

    function automatic void push_triplet(input logic [7:0] b, input logic [4:0] len,
                                         input logic l);
        logic [7:0] letter;
        letter = LETTER_A + {3'b000, len} - 8'd1;
        push_result(MARK_BYTE, 1'b0, 1'b0);
        push_result(letter, 1'b0, 1'b0);
        push_result(b, l, 1'b0);
    endfunction

    function automatic void predict_codec(input logic [7:0] b, input logic l);
        int cnt;
        if (mode_dir == DIR_ENCODE) begin
            if (enc_open && b == enc_byte && enc_len < MAX_RUN) begin
                enc_len++;
            end else begin
                // a different byte or a full chunk closes the run
                if (enc_open)
                    push_triplet(enc_byte, enc_len, 1'b0);
                enc_open = 1'b1;
                enc_byte = b;
                enc_len  = 5'd1;
            end
            if (l) begin
                push_triplet(enc_byte, enc_len, 1'b1);
                enc_open = 1'b0;
                enc_byte = '0;
                enc_len  = '0;
            end
        end else if (dec_phase == PH_DATA) begin
            if (dec_letter >= LETTER_A && dec_letter <= LETTER_Z) begin
                cnt = dec_letter - LETTER_A + 1;
                for (int i = 0; i < cnt; i++)
                    push_result(b, l && (i == cnt - 1), 1'b0);
            end else begin
                push_result(8'h00, l, 1'b1);
            end
            dec_phase  = PH_MARK;
            dec_letter = '0;
        end else begin
            // marker byte is taken as is, never checked
            if (dec_phase == PH_COUNT)
                dec_letter = b;
            dec_phase = (dec_phase == PH_MARK) ? PH_COUNT : PH_DATA;
            if (l) begin
                push_result(8'h00, 1'b1, 1'b1);
                dec_phase  = PH_MARK;
                dec_letter = '0;
            end
        end
    endfunction

    always @(posedge aclk) begin
        lcrle_out_t want;
        if (aresetn) begin
            // results first: nothing accepted at this edge can come out at it
            if (m_valid && m_ready) begin
                if (bytes_due.size() == 0) begin
                    $error("result transfer with none expected: %02h last=%0b bad=%0b",
                           m_data.out_byte, m_data.out_last, m_data.bad_input);
                    err_cnt++;
                end else begin
                    want = bytes_due.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, actual %02h",
                               want.out_byte, m_data.out_byte);
                        err_cnt++;
                    end
                    if (m_data.out_last !== want.out_last) begin
                        $error("out_last: expected %0b, actual %0b",
                               want.out_last, m_data.out_last);
                        err_cnt++;
                    end
                    if (m_data.bad_input !== want.bad_input) begin
                        $error("bad_input: expected %0b, actual %0b",
                               want.bad_input, m_data.bad_input);
                        err_cnt++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                mode_dir = cfg_data;
            if (s_valid && s_ready) begin
                predict_codec(s_data.in_byte, s_data.in_last);
                if (pin_armed && (bytes_due.size() == 0 || bytes_due[$] !== pin_want)) begin
                    $error("pinned result: expected %p, actual %p", pin_want,
                           (bytes_due.size() == 0) ? NO_PIN : bytes_due[$]);
                    err_cnt++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l, input logic pin,
                             input lcrle_out_t pv);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        pin_armed = pin;
        pin_want  = pv;
        s_valid  <= 1'b1;
        s_data   <= '{in_byte: b, in_last: l};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold the sender until every predicted result has drained.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_direction(input logic d);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic encode_stream(inout int sent);
        int         runs;
        int         len;
        logic [7:0] b;
        logic       l;
        runs = $urandom_range(4, 1);
        for (int r = 0; r < runs; r++) begin
            b = 8'($urandom_range(255));
            case ($urandom_range(9))
                0:       len = $urandom_range(30, 20);
                1, 2:    len = 1;
                default: len = $urandom_range(6, 1);
            endcase
            for (int k = 0; k < len; k++) begin
                // a stray last now and then cuts a run short
                l = (r == runs - 1 && k == len - 1) || ($urandom_range(49) == 0);
                send_byte(b, l, 1'b0, NO_PIN);
                sent++;
            end
        end
    endtask

    task automatic decode_stream(inout int sent);
        int         trips;
        int         cut;
        logic       fin;
        logic       tail;
        logic [7:0] letter;
        logic [7:0] marker;
        trips = $urandom_range(3, 1);
        fin   = ($urandom_range(4) != 0);
        cut   = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : 0;
        for (int t = 0; t < trips; t++) begin
            tail = (t == trips - 1);
            if ($urandom_range(9) == 0)
                letter = 8'($urandom_range(255));
            else if ($urandom_range(1) != 0)
                letter = 8'(LETTER_A + $urandom_range(3));
            else
                letter = 8'(LETTER_A + $urandom_range(25));
            marker = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : MARK_BYTE;
            send_byte(marker, tail && cut == 1, 1'b0, NO_PIN);
            sent++;
            if (tail && cut == 1)
                break;
            send_byte(letter, tail && cut == 2, 1'b0, NO_PIN);
            sent++;
            if (tail && cut == 2)
                break;
            send_byte(8'($urandom_range(255)), tail && fin, 1'b0, NO_PIN);
            sent++;
        end
    endtask

    initial begin
        int sent;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NROWS; i++) begin
            if (stim_tab[i].kind == ROW_DIR) begin
                write_direction(stim_tab[i].value[0]);
            end else begin
                for (int k = 0; k < stim_tab[i].reps; k++)
                    send_byte(stim_tab[i].value,
                              stim_tab[i].last && (k == stim_tab[i].reps - 1),
                              stim_tab[i].pinned && (k == stim_tab[i].reps - 1),
                              stim_tab[i].pin);
            end
        end

        // no idling, sender idle, receiver stalling, both; each in both directions
        for (int seg = 0; seg < 8; seg++) begin
            write_direction((seg % 2 == 0) ? DIR_ENCODE : DIR_DECODE);
            @(posedge aclk);
            case (seg / 2)
                0: begin src_idle = 0;  sink_stall = 0;  end
                1: begin src_idle = 80; sink_stall = 0;  end
                2: begin src_idle = 0;  sink_stall = 80; end
                default: begin src_idle = 32; sink_stall = 32; end
            endcase
            sent = 0;
            while (sent < SEG_ITEMS) begin
                if (seg % 2 == 0)
                    encode_stream(sent);
                else
                    decode_stream(sent);
            end
        end

        wait_idle();
        repeat (4 * DRAIN_CYC) @(posedge aclk);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
